[rtl/first_fit_block_allocator_defines.svh]
// ---------------------------------------------------------------------------
// first_fit_block_allocator_defines
// assertion macros for the block allocator, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
// checked property, disabled while reset is high
`define FBA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fba assertion failed");
// checked property, also active during reset
`define FBA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("fba assertion failed");
`else
`define FBA_ASSERT(lbl, clk, rst, prop)
`define FBA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[rtl/fba_pkg.sv]
// ---------------------------------------------------------------------------
// fba_pkg
// types and constants shared by the block allocator modules
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fba_pkg;

   localparam int BSIZE_W     = 16;
   localparam int BYTES_W     = 24;
   localparam int SCALE_STEPS = 16;
   localparam logic [BSIZE_W-1:0] BSIZE_RESET = 16'd64;
   localparam logic [BYTES_W-1:0] BYTES_MAX   = 24'hFFFFFF;

   typedef enum logic [1:0] {
      FUNC_ALLOC  = 2'd0,
      FUNC_FREE   = 2'd1,
      FUNC_REPORT = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_APPLY,
      ST_LOAD,
      ST_SCALE,
      ST_DONE
   } state_type;

   typedef struct packed {
      func_type   func;
      logic [7:0] start_index;
      logic [8:0] block_count;
   } req_type;

   typedef struct packed {
      logic               success;
      logic [7:0]         found_index;
      logic [BYTES_W-1:0] free_bytes;
      logic [BYTES_W-1:0] longest_free_bytes;
      logic [BYTES_W-1:0] longest_used_bytes;
      logic [7:0]         used_segments;
   } rsp_type;

   // map ring control: rotate one place, bit written into the tail
   typedef struct packed {
      logic shift;
      logic new_bit;
   } map_ctrl_type;

   // statistics control: clear before a pass, step once per block
   typedef struct packed {
      logic clear;
      logic step;
      logic bit_used;
   } stat_ctrl_type;

   // serial multiplier control
   typedef struct packed {
      logic load;
      logic step;
   } mul_ctrl_type;

endpackage

[rtl/first_fit_block_allocator.sv]
// ---------------------------------------------------------------------------
// first_fit_block_allocator
// first-fit contiguous block allocator over a rotating bitmap
// ---------------------------------------------------------------------------
// A request is taken on req_data when start is high and busy is low. It
// allocates the first free run of block_count blocks at or after
// start_index, frees a range, only reports, or clears the map. One result
// per request appears on rsp_data for a single cycle with rsp_valid high;
// the receiver cannot hold it off. csr_we/csr_wdata set the block size.
// The map is a shift register that rotates one block per clock during a
// pass, so each pass moves every block past the head. Allocate makes
// a search pass and an update pass, everything else only the update pass,
// which also gathers the statistics. The byte sizes then come from a
// bit-serial multiply. An allocate with a zero count or a start past the
// end skips the search. One request at a time. Reset frees every block at
// once and sets the block size to 64.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "first_fit_block_allocator_defines.svh"

module first_fit_block_allocator #(
   parameter int NUM_BLOCKS = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  fba_pkg::req_type             req_data,
   output logic                         rsp_valid,
   output fba_pkg::rsp_type             rsp_data,
   input  logic                         csr_we,
   input  logic [fba_pkg::BSIZE_W-1:0]  csr_wdata
);
   import fba_pkg::*;

   localparam int IW = $clog2(NUM_BLOCKS);
   localparam int SW = $clog2(NUM_BLOCKS + 1);
   localparam int CW = (SW > 10) ? SW : 10;
   localparam int GW = (SW > 9) ? SW : 9;

   state_type          state_ff, state_in;
   func_type           func_ff, func_in;
   logic [7:0]         start_ff, start_in;
   logic [8:0]         count_ff, count_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [SW-1:0]      run_ff, run_in;
   logic [IW-1:0]      run_start_ff, run_start_in;
   logic [IW-1:0]      found_ff, found_in;
   logic               hit_ff, hit_in;
   logic               ok_ff, ok_in;
   logic               mod_ff, mod_in;
   logic               wipe_ff, wipe_in;
   logic [CW-1:0]      lo_ff, lo_in;
   logic [CW-1:0]      hi_ff, hi_in;
   logic [3:0]         step_ff, step_in;
   logic [BSIZE_W-1:0] bsize_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   map_ctrl_type       map_ctrl;
   stat_ctrl_type      stat_ctrl;
   mul_ctrl_type       mul_ctrl;
   logic               cur_bit;
   logic [SW-1:0]      nfree, lfree, lused, segs;
   logic [BYTES_W-1:0] free_bytes, lfree_bytes, lused_bytes;

   logic               accept;
   logic               pass_end;
   logic [CW-1:0]      idx_ext;
   logic               active;
   logic [CW-1:0]      run_plus;
   logic               hit_now;
   logic [IW-1:0]      found_now;
   logic [IW-1:0]      found_sel;
   logic               in_range;
   logic               new_bit;
   logic               cnt_ok;
   logic [CW-1:0]      req_end;
   logic [IW+7:0]      found_wide;
   logic [GW-1:0]      segs_wide;

   // datapath parts
   fba_map_ring #(.NUM_BLOCKS(NUM_BLOCKS)) u_map (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (map_ctrl),
      .cur_bit (cur_bit)
   );

   fba_run_stats #(.NUM_BLOCKS(NUM_BLOCKS)) u_stats (
      .clock (clock),
      .ctrl  (stat_ctrl),
      .nfree (nfree),
      .lfree (lfree),
      .lused (lused),
      .segs  (segs)
   );

   fba_serial_mul #(.VALUE_W(SW)) u_mul_free (
      .clock (clock), .ctrl (mul_ctrl), .value (nfree), .mult (bsize_ff),
      .product (free_bytes)
   );

   fba_serial_mul #(.VALUE_W(SW)) u_mul_lfree (
      .clock (clock), .ctrl (mul_ctrl), .value (lfree), .mult (bsize_ff),
      .product (lfree_bytes)
   );

   fba_serial_mul #(.VALUE_W(SW)) u_mul_lused (
      .clock (clock), .ctrl (mul_ctrl), .value (lused), .mult (bsize_ff),
      .product (lused_bytes)
   );

   // search and range decode for the block at the ring head
   always_comb begin
      accept    = start && (state_ff == ST_IDLE);
      pass_end  = (idx_ff == IW'(NUM_BLOCKS - 1));
      idx_ext   = CW'(idx_ff);
      active    = (idx_ext >= CW'(start_ff));
      run_plus  = CW'(run_ff) + CW'(1);
      hit_now   = active && !cur_bit && !hit_ff && (run_plus == CW'(count_ff));
      found_now = (run_ff == '0) ? idx_ff : run_start_ff;
      found_sel = hit_now ? found_now : found_ff;
      in_range  = (idx_ext >= lo_ff) && (idx_ext < hi_ff);
      if (wipe_ff) begin
         new_bit = 1'b0;
      end else if (mod_ff && in_range) begin
         new_bit = (func_ff == FUNC_ALLOC);
      end else begin
         new_bit = cur_bit;
      end
      cnt_ok     = (req_data.block_count != '0) &&
                   (CW'(req_data.start_index) < CW'(NUM_BLOCKS));
      req_end    = CW'(req_data.start_index) + CW'(req_data.block_count);
      found_wide = {8'b0, found_ff};
      segs_wide  = GW'(segs);
   end

   // sequencer: next state, pass control and result assembly
   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      start_in     = start_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      run_in       = run_ff;
      run_start_in = run_start_ff;
      found_in     = found_ff;
      hit_in       = hit_ff;
      ok_in        = ok_ff;
      mod_in       = mod_ff;
      wipe_in      = wipe_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      step_in      = step_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      map_ctrl     = '0;
      stat_ctrl    = '0;
      mul_ctrl     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in  = req_data.func;
               start_in = req_data.start_index;
               count_in = req_data.block_count;
               idx_in   = '0;
               run_in   = '0;
               found_in = '0;
               hit_in   = 1'b0;
               wipe_in  = (req_data.func == FUNC_CLEAR);
               lo_in    = CW'(req_data.start_index);
               hi_in    = req_end;
               stat_ctrl.clear = 1'b1;
               case (req_data.func)
                  FUNC_ALLOC: begin
                     ok_in    = 1'b0;
                     mod_in   = 1'b0;
                     state_in = cnt_ok ? ST_SEARCH : ST_APPLY;
                  end
                  FUNC_FREE: begin
                     ok_in    = cnt_ok && (req_end <= CW'(NUM_BLOCKS));
                     mod_in   = cnt_ok && (req_end <= CW'(NUM_BLOCKS));
                     state_in = ST_APPLY;
                  end
                  default: begin
                     ok_in    = 1'b1;
                     mod_in   = 1'b0;
                     state_in = ST_APPLY;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            map_ctrl.shift   = 1'b1;
            map_ctrl.new_bit = cur_bit;
            if (active && !cur_bit) begin
               run_in = SW'(run_plus);
               if (run_ff == '0) begin
                  run_start_in = idx_ff;
               end
            end else begin
               run_in = '0;
            end
            if (hit_now) begin
               hit_in   = 1'b1;
               found_in = found_now;
            end
            idx_in = idx_ff + IW'(1);
            if (pass_end) begin
               idx_in   = '0;
               ok_in    = hit_ff || hit_now;
               mod_in   = hit_ff || hit_now;
               lo_in    = CW'(found_sel);
               hi_in    = CW'(found_sel) + CW'(count_ff);
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            map_ctrl.shift     = 1'b1;
            map_ctrl.new_bit   = new_bit;
            stat_ctrl.step     = 1'b1;
            stat_ctrl.bit_used = new_bit;
            idx_in = idx_ff + IW'(1);
            if (pass_end) begin
               idx_in   = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            mul_ctrl.load = 1'b1;
            step_in       = '0;
            state_in      = ST_SCALE;
         end
         ST_SCALE: begin
            mul_ctrl.step = 1'b1;
            step_in       = step_ff + 4'd1;
            if (step_ff == 4'(SCALE_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_in.success            = ok_ff;
            rsp_in.found_index        = ok_ff ? found_wide[7:0] : 8'd0;
            rsp_in.free_bytes         = free_bytes;
            rsp_in.longest_free_bytes = lfree_bytes;
            rsp_in.longest_used_bytes = lused_bytes;
            rsp_in.used_segments      = (segs_wide > GW'(255)) ? 8'hFF : segs_wide[7:0];
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bsize_ff     <= BSIZE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            bsize_ff <= csr_wdata;
         end
      end
   end

   // request and pass registers
   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      start_ff     <= start_in;
      count_ff     <= count_in;
      idx_ff       <= idx_in;
      run_ff       <= run_in;
      run_start_ff <= run_start_in;
      found_ff     <= found_in;
      hit_ff       <= hit_in;
      ok_ff        <= ok_in;
      mod_ff       <= mod_in;
      wipe_ff      <= wipe_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      step_ff      <= step_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `FBA_ASSERT(a_one_rsp_per_req, clock, reset, rsp_valid |=> !rsp_valid)
   `FBA_ASSERT(a_busy_after_accept, clock, reset, (start && !busy) |=> busy)
   `FBA_ASSERT(a_rsp_from_done, clock, reset, rsp_valid |-> $past(state_ff == ST_DONE))
   `FBA_ASSERT(a_fail_no_index, clock, reset,
      (rsp_valid && !rsp_data.success) |-> (rsp_data.found_index == 8'd0))
   `FBA_ASSERT_ALWAYS(a_idle_in_reset, clock, $past(reset) |-> !busy)

endmodule

[rtl/fba_map_ring.sv]
// ---------------------------------------------------------------------------
// fba_map_ring
// block map held as a rotating shift register, one block per cycle while shifting
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fba_map_ring #(
   parameter int NUM_BLOCKS = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fba_pkg::map_ctrl_type ctrl,
   output logic                 cur_bit
);
   import fba_pkg::*;

   logic [NUM_BLOCKS-1:0] map_ff;
   logic [NUM_BLOCKS-1:0] map_in;

   // head bit leaves, rewritten bit enters at the tail
   always_comb begin
      map_in = map_ff;
      if (ctrl.shift) begin
         map_in = {ctrl.new_bit, map_ff[NUM_BLOCKS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= '0;
      end else begin
         map_ff <= map_in;
      end
   end

   assign cur_bit = map_ff[0];

endmodule

[rtl/fba_run_stats.sv]
// ---------------------------------------------------------------------------
// fba_run_stats
// free count, longest runs and used segment count over one map pass
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fba_run_stats #(
   parameter int NUM_BLOCKS = 256
) (
   input  logic                                 clock,
   input  fba_pkg::stat_ctrl_type               ctrl,
   output logic [$clog2(NUM_BLOCKS+1)-1:0]      nfree,
   output logic [$clog2(NUM_BLOCKS+1)-1:0]      lfree,
   output logic [$clog2(NUM_BLOCKS+1)-1:0]      lused,
   output logic [$clog2(NUM_BLOCKS+1)-1:0]      segs
);
   import fba_pkg::*;

   localparam int SW = $clog2(NUM_BLOCKS + 1);

   logic [SW-1:0] nfree_ff, frun_ff, urun_ff, lfree_ff, lused_ff, segs_ff;
   logic [SW-1:0] nfree_in, frun_in, urun_in, lfree_in, lused_in, segs_in;
   logic [SW-1:0] urun_inc, frun_inc;

   // run tracking for the bit at the head of the ring
   always_comb begin
      urun_inc = urun_ff + SW'(1);
      frun_inc = frun_ff + SW'(1);
      nfree_in = nfree_ff;
      frun_in  = frun_ff;
      urun_in  = urun_ff;
      lfree_in = lfree_ff;
      lused_in = lused_ff;
      segs_in  = segs_ff;
      if (ctrl.clear) begin
         nfree_in = '0;
         frun_in  = '0;
         urun_in  = '0;
         lfree_in = '0;
         lused_in = '0;
         segs_in  = '0;
      end else if (ctrl.step) begin
         if (ctrl.bit_used) begin
            if (urun_ff == '0) begin
               segs_in = segs_ff + SW'(1);
            end
            urun_in = urun_inc;
            frun_in = '0;
            if (urun_inc > lused_ff) begin
               lused_in = urun_inc;
            end
         end else begin
            nfree_in = nfree_ff + SW'(1);
            frun_in  = frun_inc;
            urun_in  = '0;
            if (frun_inc > lfree_ff) begin
               lfree_in = frun_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      nfree_ff <= nfree_in;
      frun_ff  <= frun_in;
      urun_ff  <= urun_in;
      lfree_ff <= lfree_in;
      lused_ff <= lused_in;
      segs_ff  <= segs_in;
   end

   assign nfree = nfree_ff;
   assign lfree = lfree_ff;
   assign lused = lused_ff;
   assign segs  = segs_ff;

endmodule

[rtl/fba_serial_mul.sv]
// ---------------------------------------------------------------------------
// fba_serial_mul
// bit-serial multiply by the block size, msb first, saturating to 24 bits
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fba_serial_mul #(
   parameter int VALUE_W = 9
) (
   input  logic                           clock,
   input  fba_pkg::mul_ctrl_type          ctrl,
   input  logic [VALUE_W-1:0]             value,
   input  logic [fba_pkg::BSIZE_W-1:0]    mult,
   output logic [fba_pkg::BYTES_W-1:0]    product
);
   import fba_pkg::*;

   localparam int AW = VALUE_W + BSIZE_W;
   localparam int EW = (AW > BYTES_W + 1) ? AW : BYTES_W + 1;

   logic [AW-1:0]      acc_ff, acc_in;
   logic [BSIZE_W-1:0] mult_ff, mult_in;
   logic [EW-1:0]      acc_ext;

   // shift and add, one multiplier bit per step
   always_comb begin
      acc_in  = acc_ff;
      mult_in = mult_ff;
      if (ctrl.load) begin
         acc_in  = '0;
         mult_in = mult;
      end else if (ctrl.step) begin
         acc_in  = {acc_ff[AW-2:0], 1'b0} + (mult_ff[BSIZE_W-1] ? AW'(value) : '0);
         mult_in = {mult_ff[BSIZE_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      mult_ff <= mult_in;
   end

   // clamp to the byte field range
   always_comb begin
      acc_ext = EW'(acc_ff);
      product = (acc_ext > EW'(BYTES_MAX)) ? BYTES_MAX : acc_ext[BYTES_W-1:0];
   end

endmodule
